[sv/sha_pkg.sv]
// Package for the byte-serial SHA-256 hasher: constants, round constants and helper functions.
// Used by sha_queue, sha_core, sha_front and the top level; depends on nothing.
package sha_pkg;

  localparam int unsigned QueueDepthDefault = 4;
  localparam int unsigned RamDepthDefault   = 16;
  localparam logic [7:0]  PadByte           = 8'h80;
  localparam logic [5:0]  LenOffset         = 6'd56;

  // Request as it travels from the front part to the back part.
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       fin;
  } req_t;

  typedef logic [31:0] word_t;

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t v;
    case (idx)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t v;
    case (idx)
      6'd0: v = 32'h428a2f98;  6'd1: v = 32'h71374491;
      6'd2: v = 32'hb5c0fbcf;  6'd3: v = 32'he9b5dba5;
      6'd4: v = 32'h3956c25b;  6'd5: v = 32'h59f111f1;
      6'd6: v = 32'h923f82a4;  6'd7: v = 32'hab1c5ed5;
      6'd8: v = 32'hd807aa98;  6'd9: v = 32'h12835b01;
      6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7; 6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f; 6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8; 6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85; 6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e; 6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819; 6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c; 6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee; 6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7;
      default: v = 32'hc67178f2;
    endcase
    return v;
  endfunction

  function automatic word_t ror(input word_t v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

endpackage

[sv/sha_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module sha_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[sv/sha_queue.sv]
// Short request queue between the front and back parts.
// Depends on sha_pkg.
module sha_queue import sha_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t wreq,
  output logic full,
  input  logic pop,
  output req_t rreq,
  output logic empty
);
  localparam int unsigned AW = $clog2(Depth);
  req_t mem [Depth];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;
  logic do_push;
  logic do_pop;

  assign full    = (count == (AW+1)'(Depth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rreq    = mem[rptr];

  // Storage writes.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wreq;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(Depth - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(Depth - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

[sv/sha_core.sv]
// Back part: block assembly, padding, 64-round compression and digest output.
// Depends on sha_pkg and sha_ram.
module sha_core import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  req_t        req,
  output logic        req_take,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word,
  output logic        empty,
  input  logic        pop
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StLen  = 3'd2;
  localparam logic [2:0] StComp = 3'd3;
  localparam logic [2:0] StAdd  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]  state;
  logic [5:0]  fill;
  logic [60:0] msg_bytes;
  logic        finishing;
  logic        padding;
  logic        in_len_block;
  logic        byte_pending;
  logic [7:0]  pend_byte;
  logic [31:0] word_acc;
  logic [63:0] bit_len;
  logic [6:0]  round;
  logic [2:0]  out_idx;
  word_t       h [8];
  word_t       r [8];
  word_t       w [16];

  // Message words of the current block in a small RAM, 16 words of 32 bits.
  logic        ram_we;
  logic [3:0]  ram_waddr;
  logic [31:0] ram_wdata;
  logic [3:0]  ram_raddr;
  logic [31:0] ram_rdata;

  sha_ram #(.Width(32), .Depth(RamDepthDefault)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // The byte written into the block this cycle, if any.
  logic       put;
  logic [7:0] put_byte;
  always_comb begin
    put      = 1'b0;
    put_byte = '0;
    case (state)
      StIdle: begin
        if (byte_pending) begin
          put = 1'b1; put_byte = pend_byte;
        end else if (finishing) begin
          put = 1'b1; put_byte = PadByte;
        end
      end
      StPad: begin
        put = 1'b1; put_byte = 8'h00;
      end
      StLen: begin
        put = 1'b1; put_byte = bit_len[63:56];
      end
      default: ;
    endcase
  end

  logic [31:0] acc_next;
  assign acc_next  = {word_acc[23:0], put_byte};
  assign ram_we    = put && (fill[1:0] == 2'd3);
  assign ram_waddr = fill[5:2];
  assign ram_wdata = acc_next;
  assign req_take  = (state == StIdle) && !byte_pending && !finishing && req_valid;

  // Schedule and round logic. The RAM is read in the round before the one that uses it,
  // so word 0 is addressed while the block is still being filled.
  logic [5:0]  ridx;
  word_t       wt;
  word_t       s0;
  word_t       s1;
  word_t       wnew;
  word_t       t1;
  word_t       t2;
  assign ridx = round[5:0];
  assign s0   = ror(w[1], 7) ^ ror(w[1], 18) ^ (w[1] >> 3);
  assign s1   = ror(w[14], 17) ^ ror(w[14], 19) ^ (w[14] >> 10);
  assign wnew = w[0] + s0 + w[9] + s1;
  assign wt   = (ridx < 6'd16) ? ram_rdata : wnew;
  assign ram_raddr = (state == StComp && ridx < 6'd15) ? 4'(ridx + 6'd1) : 4'd0;
  assign t1 = r[7] + (ror(r[4], 6) ^ ror(r[4], 11) ^ ror(r[4], 25))
            + ((r[4] & r[5]) ^ (~r[4] & r[6])) + round_k(ridx) + wt;
  assign t2 = (ror(r[0], 2) ^ ror(r[0], 13) ^ ror(r[0], 22))
            + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));

  assign digest_word = h[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == 3'd7);
  assign empty       = (state != StOut);

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= StIdle;
      fill         <= '0;
      msg_bytes    <= '0;
      finishing    <= 1'b0;
      padding      <= 1'b0;
      in_len_block <= 1'b0;
      byte_pending <= 1'b0;
      round        <= '0;
      out_idx      <= '0;
      for (int i = 0; i < 8; i++) h[i] <= init_hash(3'(i));
    end else begin
      if (put) begin
        word_acc <= acc_next;
        fill     <= fill + 6'd1;
      end
      case (state)
        StIdle: begin
          if (req_take) begin
            byte_pending <= req.present;
            pend_byte    <= req.data;
            finishing    <= req.fin;
            if (req.present) msg_bytes <= msg_bytes + 61'd1;
            if (req.fin) bit_len <= {(req.present ? msg_bytes + 61'd1 : msg_bytes), 3'b000};
          end else if (byte_pending) begin
            // A message byte; a full block goes to compression.
            byte_pending <= 1'b0;
            if (fill == 6'd63) begin
              state <= StComp; round <= '0;
              for (int i = 0; i < 8; i++) r[i] <= h[i];
            end
          end else if (finishing) begin
            // The pad byte starts the padding of the last block.
            finishing <= 1'b0;
            padding   <= 1'b1;
            if (fill == 6'd63) begin
              state <= StComp; round <= '0;
              for (int i = 0; i < 8; i++) r[i] <= h[i];
            end else if (fill == LenOffset - 6'd1) begin
              state <= StLen;
            end else begin
              state <= StPad;
            end
          end
        end
        StPad: begin
          if (fill == 6'd63) begin
            state <= StComp; round <= '0;
            for (int i = 0; i < 8; i++) r[i] <= h[i];
          end else if (fill == LenOffset - 6'd1) begin
            state <= StLen;
          end
        end
        StLen: begin
          bit_len      <= {bit_len[55:0], 8'h00};
          in_len_block <= 1'b1;
          if (fill == 6'd63) begin
            state <= StComp; round <= '0;
            for (int i = 0; i < 8; i++) r[i] <= h[i];
          end
        end
        StComp: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wt;
          r[7] <= r[6]; r[6] <= r[5]; r[5] <= r[4]; r[4] <= r[3] + t1;
          r[3] <= r[2]; r[2] <= r[1]; r[1] <= r[0]; r[0] <= t1 + t2;
          round <= round + 7'd1;
          if (round == 7'd63) state <= StAdd;
        end
        StAdd: begin
          // The length block ends the message; otherwise padding or input resumes.
          for (int i = 0; i < 8; i++) h[i] <= h[i] + r[i];
          if (in_len_block) begin
            state <= StOut;
          end else if (padding) begin
            state <= StPad;
          end else begin
            state <= StIdle;
          end
        end
        StOut: begin
          if (pop) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              state        <= StIdle;
              msg_bytes    <= '0;
              fill         <= '0;
              padding      <= 1'b0;
              in_len_block <= 1'b0;
              for (int i = 0; i < 8; i++) h[i] <= init_hash(3'(i));
            end
          end
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule

[sv/sha_front.sv]
// Front part: accepts input requests, drops requests that carry nothing.
// Depends on sha_pkg.
module sha_front import sha_pkg::*; (
  input  logic       data_present_in,
  input  logic [7:0] data_in,
  input  logic       fin_in,
  input  logic       push,
  input  logic       q_full,
  output logic       q_push,
  output req_t       q_req
);
  // Requests with neither a byte nor an end mark change nothing.
  assign q_push = push && !q_full && (data_present_in || fin_in);
  assign q_req  = '{data: data_in, present: data_present_in, fin: fin_in};
endmodule

[sv/sha256_stream_hasher_top.sv]
// Top level of the byte-serial SHA-256 hasher.
// Depends on sha_pkg, sha_front, sha_queue, sha_core.
//
// Use: message bytes enter one request at a time through a queue-style port
// (push/full). A request carries data_byte when byte_present is high; a
// request with end_of_message high closes the message, optionally after its
// byte. Empty messages are allowed.
// Results leave through a queue-style port (empty/pop): eight requests per
// message, digest words 0 to 7, last_word high on the eighth.
// Each byte is first taken from the queue and then written into the block;
// the core takes no new byte before the last one is written. Every 64th byte
// adds a compression of 64 rounds and a hash update, done by the single round unit.
// Ending a message writes 9 to 72 pad and length bytes, runs one or two
// compressions, then shows the digest words one per pop.
// The input queue absorbs requests during compression; full rises when it
// has no room.
// Reset loads the initial hash values and clears the byte count and queue.
// When the receiver stalls the digest holds and input stops once full.
module sha256_stream_hasher_top import sha_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  logic q_push;
  req_t q_wreq;
  req_t q_rreq;
  logic q_empty;
  logic q_take;

  sha_front u_front (
    .data_present_in(byte_present), .data_in(data_byte), .fin_in(end_of_message),
    .push(push), .q_full(full), .q_push(q_push), .q_req(q_wreq)
  );

  sha_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst(rst), .push(q_push), .wreq(q_wreq), .full(full),
    .pop(q_take), .rreq(q_rreq), .empty(q_empty)
  );

  sha_core u_core (
    .clk(clk), .rst(rst), .req_valid(!q_empty), .req(q_rreq), .req_take(q_take),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word),
    .empty(empty), .pop(pop)
  );

  // The core never takes from an empty queue.
  assert property (@(posedge clk) disable iff (rst) q_take |-> !q_empty)
    else $error("request taken from empty queue");
  // A popped final word returns the output side to empty.
  assert property (@(posedge clk) disable iff (rst) (pop && !empty && last_word) |=> empty)
    else $error("output still shown after last word");
  // Word index advances by one on every pop that is not the last.
  assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last_word) |=> (word_index == $past(word_index) + 3'd1))
    else $error("word index skipped");
endmodule
